// ----- hdl/stsc_pkg.sv -----
// Shared types and constants for the sample-timer sync compensator.
// Used by stsc_front, stsc_back and the top level; no dependencies.
`default_nettype none

package stsc_pkg;

  // Operation codes on the input channel
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_REQUEST = 3'd1;
  localparam logic [2:0] OP_PERIOD  = 3'd2;
  localparam logic [2:0] OP_SAMPLE  = 3'd3;
  localparam logic [2:0] OP_START   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_NOMINAL_TICKS  = 3'd0;
  localparam logic [2:0] CFG_SAMPLES_PERIOD = 3'd1;
  localparam logic [2:0] CFG_SAMPLE_NS      = 3'd2;
  localparam logic [2:0] CFG_SYNC_NS        = 3'd3;
  localparam logic [2:0] CFG_TICK_NS        = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register values after reset
  localparam logic [15:0] RST_NOMINAL_TICKS  = 16'd2000;
  localparam logic [15:0] RST_SAMPLES_PERIOD = 16'd10000;
  localparam logic [31:0] RST_SAMPLE_NS      = 32'd10000;
  localparam logic [31:0] RST_SYNC_NS        = 32'd100000000;
  localparam logic [7:0]  RST_TICK_NS        = 8'd5;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_TICK,
    CMD_REQUEST,
    CMD_PERIOD,
    CMD_SAMPLE,
    CMD_START
  } cmd_kind_t;

  // Classified command. data carries the timer value for a request,
  // {reply_ticks, reply_remainder} for a sample trigger, and the start
  // timestamp for a start.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        reply_valid;
    logic [63:0] data;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/sample_timer_sync_compensator.sv -----
// Each accepted event passes through the command queue and then the result register.
// Throughput: one event per cycle, sustained unless the result channel stalls the back end.
// The two-entry command queue and the result register let either side stall on its own.
// Reset (rst, synchronous): empties the queue and result register, restores register defaults
// and clears compensation state; the compare value starts at the default sample interval.
// Top level of the sample-timer sync compensator; depends on stsc_pkg, stsc_front, stsc_back.
`default_nettype none

module sample_timer_sync_compensator
  import stsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Timer event channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [2:0]            operation,
  input  wire logic [31:0]           timer_count,
  input  wire logic                  reply_valid,
  input  wire logic [31:0]           reply_ticks,
  input  wire logic [15:0]           reply_remainder,
  input  wire logic [63:0]           start_timestamp,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       compensate_now,
  output logic [8:0]                 step_ns,
  output logic [31:0]                sample_compare,
  output logic                       send_valid,
  output logic [31:0]                send_timestamp,
  output logic                       sync_error,
  output logic [63:0]                next_sync_ts,
  output logic [31:0]                pending_steps
);

  // Classified command passing from front to back
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  // Front: decode the operation code and hold up to two commands, so
  // that a stalled result channel does not stop the request at once.
  stsc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .timer_count     (timer_count),
    .reply_valid     (reply_valid),
    .reply_ticks     (reply_ticks),
    .reply_remainder (reply_remainder),
    .start_timestamp (start_timestamp),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready)
  );

  // Back: apply each command to the compensation state (tick spend,
  // Bresenham carry, compare wrap, sync timestamp) and register the
  // result; advance whenever the result register is free or being taken.
  stsc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .compensate_now (compensate_now),
    .step_ns        (step_ns),
    .sample_compare (sample_compare),
    .send_valid     (send_valid),
    .send_timestamp (send_timestamp),
    .sync_error     (sync_error),
    .next_sync_ts   (next_sync_ts),
    .pending_steps  (pending_steps)
  );

endmodule

`default_nettype wire

// ----- hdl/stsc_front.sv -----
// Front end: accepts timer events, classifies them into commands and
// queues them for the back end. Depends on stsc_pkg.
`default_nettype none

module stsc_front
  import stsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] timer_count,
  input  wire logic        reply_valid,
  input  wire logic [31:0] reply_ticks,
  input  wire logic [15:0] reply_remainder,
  input  wire logic [63:0] start_timestamp,
  output cmd_t             cmd,
  output logic             cmd_valid,
  input  wire logic        cmd_ready
);

  cmd_t              decoded;
  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  always_comb begin
    decoded             = '0;
    decoded.reply_valid = reply_valid;
    unique case (operation)
      OP_TICK: begin
        decoded.kind = CMD_TICK;
      end
      OP_REQUEST: begin
        decoded.kind = CMD_REQUEST;
        decoded.data = {32'd0, timer_count};
      end
      OP_PERIOD: begin
        decoded.kind = CMD_PERIOD;
      end
      OP_SAMPLE: begin
        decoded.kind = CMD_SAMPLE;
        decoded.data = {16'd0, reply_ticks, reply_remainder};
      end
      OP_START: begin
        decoded.kind = CMD_START;
        decoded.data = start_timestamp;
      end
      default: begin
        decoded.kind = CMD_NONE;
      end
    endcase
  end

  assign in_ready  = (count != QCNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/stsc_back.sv -----
// Back end: holds configuration and compensation state, executes one command per cycle
// into a registered result unless that result is stalled. Depends on stsc_pkg.
`default_nettype none

module stsc_back
  import stsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire cmd_t                  cmd,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       compensate_now,
  output logic [8:0]                 step_ns,
  output logic [31:0]                sample_compare,
  output logic                       send_valid,
  output logic [31:0]                send_timestamp,
  output logic                       sync_error,
  output logic [63:0]                next_sync_ts,
  output logic [31:0]                pending_steps
);

  // Configuration
  logic [15:0] nominal_ticks;
  logic [15:0] samples_period;
  logic [31:0] sample_ns;
  logic [31:0] sync_ns;
  logic [7:0]  tick_ns;

  // State
  logic [31:0] pending_count,   pending_count_next;
  logic [31:0] steps_sample,    steps_sample_next;
  logic [15:0] fraction_acc,    fraction_acc_next;
  logic [15:0] fraction_step,   fraction_step_next;
  logic        reply_waiting,   reply_waiting_next;
  logic [31:0] saved_ticks,     saved_ticks_next;
  logic [15:0] saved_fraction,  saved_fraction_next;
  logic [31:0] compare_value,   compare_value_next;
  logic [63:0] sync_ts,         sync_ts_next;
  logic [8:0]  step_inc,        step_inc_next;

  logic        comp_next;
  logic        sendv_next;
  logic [31:0] sendts_next;
  logic        err_next;
  logic        take;

  // Arithmetic used by the command arms
  logic [32:0] compare_sum;
  logic [32:0] compare_wrapped;
  logic [16:0] frac_sum;
  logic [16:0] frac_wrapped;
  logic        frac_carry;
  logic [33:0] pend_sum;
  logic [31:0] nominal_ext;
  logic        ticks_above;

  assign take      = cmd_valid && (!out_valid || out_ready);
  assign cmd_ready = take;

  assign compare_sum     = {1'b0, compare_value} + {1'b0, sample_ns};
  assign compare_wrapped = compare_sum - {1'b0, sync_ns};
  assign frac_sum        = {1'b0, fraction_acc} + {1'b0, fraction_step};
  assign frac_carry      = (frac_sum >= {1'b0, samples_period});
  assign frac_wrapped    = frac_sum - {1'b0, samples_period};
  assign pend_sum        = {2'b00, pending_count} + {2'b00, steps_sample}
                         + {33'd0, frac_carry};
  assign nominal_ext     = {16'd0, nominal_ticks};
  assign ticks_above     = (saved_ticks >= nominal_ext);

  always_comb begin
    pending_count_next  = pending_count;
    steps_sample_next   = steps_sample;
    fraction_acc_next   = fraction_acc;
    fraction_step_next  = fraction_step;
    reply_waiting_next  = reply_waiting;
    saved_ticks_next    = saved_ticks;
    saved_fraction_next = saved_fraction;
    compare_value_next  = compare_value;
    sync_ts_next        = sync_ts;
    step_inc_next       = step_inc;
    comp_next           = 1'b0;
    sendv_next          = 1'b0;
    sendts_next         = '0;
    err_next            = 1'b0;
    unique case (cmd.kind)
      CMD_TICK: begin
        if (pending_count != '0) begin
          comp_next          = 1'b1;
          pending_count_next = pending_count - 32'd1;
        end
      end
      CMD_REQUEST: begin
        if (!reply_waiting) begin
          reply_waiting_next = 1'b1;
          sendv_next         = 1'b1;
          sendts_next        = cmd.data[31:0];
        end else begin
          // Request met a pending reply: drop everything back to reset values, taken from the current registers
          err_next            = 1'b1;
          pending_count_next  = '0;
          steps_sample_next   = '0;
          fraction_acc_next   = '0;
          fraction_step_next  = '0;
          reply_waiting_next  = 1'b0;
          saved_ticks_next    = '0;
          saved_fraction_next = '0;
          compare_value_next  = sample_ns;
          sync_ts_next        = '0;
          step_inc_next       = {1'b0, tick_ns};
        end
      end
      CMD_PERIOD: begin
        sync_ts_next = sync_ts + {32'd0, sync_ns};
        if (ticks_above) begin
          steps_sample_next = saved_ticks - nominal_ext;
          step_inc_next     = (tick_ns == '0) ? '0 : {1'b0, tick_ns} - 9'd1;
        end else begin
          steps_sample_next = nominal_ext - saved_ticks;
          step_inc_next     = {1'b0, tick_ns} + 9'd1;
        end
        fraction_step_next = saved_fraction;
        fraction_acc_next  = '0;
      end
      CMD_SAMPLE: begin
        compare_value_next = (compare_sum > {1'b0, sync_ns}) ?
                             compare_wrapped[31:0] : compare_sum[31:0];
        pending_count_next = (pend_sum[33:32] != 2'b00) ? '1 : pend_sum[31:0];
        fraction_acc_next  = frac_carry ? frac_wrapped[15:0] : frac_sum[15:0];
        if (cmd.reply_valid) begin
          saved_ticks_next    = cmd.data[47:16];
          saved_fraction_next = cmd.data[15:0];
          reply_waiting_next  = 1'b0;
        end
      end
      CMD_START: begin
        sync_ts_next = cmd.data;
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      nominal_ticks  <= RST_NOMINAL_TICKS;
      samples_period <= RST_SAMPLES_PERIOD;
      sample_ns      <= RST_SAMPLE_NS;
      sync_ns        <= RST_SYNC_NS;
      tick_ns        <= RST_TICK_NS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NOMINAL_TICKS:  nominal_ticks  <= cfg_data[15:0];
        CFG_SAMPLES_PERIOD: samples_period <= cfg_data[15:0];
        CFG_SAMPLE_NS:      sample_ns      <= cfg_data;
        CFG_SYNC_NS:        sync_ns        <= cfg_data;
        CFG_TICK_NS:        tick_ns        <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count  <= '0;
      steps_sample   <= '0;
      fraction_acc   <= '0;
      fraction_step  <= '0;
      reply_waiting  <= 1'b0;
      saved_ticks    <= '0;
      saved_fraction <= '0;
      compare_value  <= RST_SAMPLE_NS;
      sync_ts        <= '0;
      step_inc       <= {1'b0, RST_TICK_NS};
      out_valid      <= 1'b0;
    end else if (take) begin
      pending_count  <= pending_count_next;
      steps_sample   <= steps_sample_next;
      fraction_acc   <= fraction_acc_next;
      fraction_step  <= fraction_step_next;
      reply_waiting  <= reply_waiting_next;
      saved_ticks    <= saved_ticks_next;
      saved_fraction <= saved_fraction_next;
      compare_value  <= compare_value_next;
      sync_ts        <= sync_ts_next;
      step_inc       <= step_inc_next;
      out_valid      <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take) begin
      compensate_now <= comp_next;
      step_ns        <= step_inc_next;
      sample_compare <= compare_value_next;
      send_valid     <= sendv_next;
      send_timestamp <= sendts_next;
      sync_error     <= err_next;
      next_sync_ts   <= sync_ts_next;
      pending_steps  <= pending_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/sample_timer_sync_compensator_test.sv -----
// Self-checking testbench for the sample-timer sync compensator.
// Predicts every result in the testbench and checks each one on the result channel.
// Depends on stsc_pkg and the sample_timer_sync_compensator top level.

module sample_timer_sync_compensator_test
  import stsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD     = 2;
  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 4;     // slack after the last result is back
  localparam int TAIL_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_AFTER  = 100;   // results seen before the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int PHASE_ITEMS     = 150;

  // One timer event as offered on the input channel
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] timer;
    logic        rvalid;
    logic [31:0] rticks;
    logic [15:0] rrem;
    logic [63:0] start_ts;
  } timer_event_t;

  // One result as it should appear on the result channel
  typedef struct packed {
    logic        comp;
    logic [8:0]  step;
    logic [31:0] cmp;
    logic        sendv;
    logic [31:0] sendts;
    logic        err;
    logic [63:0] sync_ts;
    logic [31:0] pend;
  } comp_result_t;

  logic                  clk             = 1'b0;
  logic                  rst             = 1'b1;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic [2:0]            operation       = '0;
  logic [31:0]           timer_count     = '0;
  logic                  reply_valid     = 1'b0;
  logic [31:0]           reply_ticks     = '0;
  logic [15:0]           reply_remainder = '0;
  logic [63:0]           start_timestamp = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b0;
  logic                  compensate_now;
  logic [8:0]            step_ns;
  logic [31:0]           sample_compare;
  logic                  send_valid;
  logic [31:0]           send_timestamp;
  logic                  sync_error;
  logic [63:0]           next_sync_ts;
  logic [31:0]           pending_steps;

  sample_timer_sync_compensator i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .timer_count     (timer_count),
    .reply_valid     (reply_valid),
    .reply_ticks     (reply_ticks),
    .reply_remainder (reply_remainder),
    .start_timestamp (start_timestamp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .compensate_now  (compensate_now),
    .step_ns         (step_ns),
    .sample_compare  (sample_compare),
    .send_valid      (send_valid),
    .send_timestamp  (send_timestamp),
    .sync_error      (sync_error),
    .next_sync_ts    (next_sync_ts),
    .pending_steps   (pending_steps)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the registers and of the compensation state
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_nominal   = RST_NOMINAL_TICKS;
  logic [15:0] cfg_samples   = RST_SAMPLES_PERIOD;
  logic [31:0] cfg_sample_ns = RST_SAMPLE_NS;
  logic [31:0] cfg_sync_ns   = RST_SYNC_NS;
  logic [7:0]  cfg_tick      = RST_TICK_NS;

  logic [31:0] pend_count;
  logic [31:0] steps_per_smp;
  logic [15:0] frac_acc;
  logic [15:0] frac_step;
  logic        awaiting_reply;
  logic [31:0] held_ticks;
  logic [15:0] held_frac;
  logic [31:0] cmp_val;
  logic [63:0] sync_ts;
  logic [8:0]  step_inc;

  timer_event_t pending_events[$];     // requests still to be offered
  comp_result_t expected_results[$];   // predicted results, oldest first

  int items_issued  = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;
  bit req_taken     = 1'b0;
  int tx_gap        = 0;
  int tx_burst      = 0;
  int rx_gap        = 0;
  int rx_hold       = 0;
  int rx_burst      = 0;
  bit long_hold_done = 1'b0;
  timer_event_t next_event;

  // Return every state entry to its reset value, using the current registers
  task automatic clear_compensator();
    pend_count     = '0;
    steps_per_smp  = '0;
    frac_acc       = '0;
    frac_step      = '0;
    awaiting_reply = 1'b0;
    held_ticks     = '0;
    held_frac      = '0;
    cmp_val        = cfg_sample_ns;
    sync_ts        = '0;
    step_inc       = {1'b0, cfg_tick};
  endtask

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  // Apply one timer event to the shadow state and work out its result
  task automatic advance_compensator(input timer_event_t ev, output comp_result_t res);
    logic [32:0] cmp_sum;
    logic [16:0] frac_sum;
    res = '0;
    case (ev.op)
      OP_TICK: begin
        if (pend_count != 0) begin
          res.comp   = 1'b1;
          pend_count = pend_count - 32'd1;
        end
      end
      OP_REQUEST: begin
        if (!awaiting_reply) begin
          awaiting_reply = 1'b1;
          res.sendv      = 1'b1;
          res.sendts     = ev.timer;
        end else begin
          // a second request before the reply: flag it and drop all state
          res.err = 1'b1;
          clear_compensator();
        end
      end
      OP_PERIOD: begin
        sync_ts = sync_ts + {32'h0, cfg_sync_ns};
        if (held_ticks >= {16'h0, cfg_nominal}) begin
          steps_per_smp = held_ticks - {16'h0, cfg_nominal};
          step_inc      = (cfg_tick != 0) ? {1'b0, cfg_tick} - 9'd1 : 9'd0;
        end else begin
          steps_per_smp = {16'h0, cfg_nominal} - held_ticks;
          step_inc      = {1'b0, cfg_tick} + 9'd1;
        end
        frac_step = held_frac;
        frac_acc  = '0;
      end
      OP_SAMPLE: begin
        // wrap the compare value once it passes the sync interval
        cmp_sum = {1'b0, cmp_val} + {1'b0, cfg_sample_ns};
        if (cmp_sum > {1'b0, cfg_sync_ns}) cmp_sum = cmp_sum - {1'b0, cfg_sync_ns};
        cmp_val    = cmp_sum[31:0];
        pend_count = sat_add(pend_count, steps_per_smp);
        // Bresenham carry: at most one modulus comes off, low 16 bits kept
        frac_sum = {1'b0, frac_acc} + {1'b0, frac_step};
        if (frac_sum >= {1'b0, cfg_samples}) begin
          pend_count = sat_add(pend_count, 32'd1);
          frac_sum   = frac_sum - {1'b0, cfg_samples};
        end
        frac_acc = frac_sum[15:0];
        if (ev.rvalid) begin
          held_ticks     = ev.rticks;
          held_frac      = ev.rrem;
          awaiting_reply = 1'b0;
        end
      end
      OP_START: begin
        sync_ts = ev.start_ts;
      end
      default: begin
        // spare codes leave the state alone
      end
    endcase
    res.step    = step_inc;
    res.cmp     = cmp_val;
    res.sync_ts = sync_ts;
    res.pend    = pend_count;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Mostly back-to-back, sometimes short gaps, now and then a long one;
  // a burst switches idling off for a stretch
  function automatic int draw_gap(inout int burst_left);
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic timer_event_t random_event(input logic [2:0] op);
    timer_event_t ev;
    ev.op       = op;
    ev.timer    = $urandom;
    ev.rvalid   = 1'($urandom_range(0, 1));
    ev.rticks   = $urandom;
    ev.rrem     = 16'($urandom);
    ev.start_ts = {$urandom, $urandom};
    return ev;
  endfunction

  task automatic offer(input timer_event_t ev);
    pending_events.push_back(ev);
    items_issued++;
  endtask

  // value goes to the field the operation uses: timer for a request,
  // {ticks, remainder} for a sample trigger, the timestamp for a start
  task automatic queue_directed(input logic [2:0] op, input logic rvalid,
                                input logic [63:0] value);
    timer_event_t ev;
    ev        = random_event(op);
    ev.rvalid = rvalid;
    case (op)
      OP_REQUEST: ev.timer = value[31:0];
      OP_SAMPLE: begin
        ev.rticks = value[47:16];
        ev.rrem   = value[15:0];
      end
      OP_START: ev.start_ts = value;
      default: begin
      end
    endcase
    offer(ev);
  endtask

  // Mostly whole sync periods (request, reply on a sample, period start,
  // then samples and ticks); the rest is noise, double requests among it
  task automatic queue_sync_traffic(input int count);
    int added;
    int n_samples;
    int offs;
    int ticks_want;
    timer_event_t ev;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 9) == 0) begin
          offer(random_event(OP_START));
          added++;
        end
        offer(random_event(OP_REQUEST));
        added++;
        n_samples = $urandom_range(1, 4);
        for (int k = 0; k < n_samples; k++) begin
          ev        = random_event(OP_SAMPLE);
          ev.rvalid = (k == n_samples - 1);
          if (ev.rvalid) begin
            if ($urandom_range(0, 99) < 85) begin
              offs       = $urandom_range(0, 12);
              ticks_want = int'(cfg_nominal) + offs - 6;
              ev.rticks  = (ticks_want < 0) ? 32'd0 : 32'(ticks_want);
            end
            if ($urandom_range(0, 99) < 70) ev.rrem = 16'($urandom_range(0, cfg_samples));
          end
          offer(ev);
          added++;
        end
        offer(random_event(OP_PERIOD));
        added++;
        repeat ($urandom_range(2, 10)) begin
          ev        = random_event(OP_SAMPLE);
          ev.rvalid = 1'b0;
          offer(ev);
          added++;
          repeat ($urandom_range(0, 8)) begin
            offer(random_event(OP_TICK));
            added++;
          end
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          offer(random_event(3'($urandom_range(0, 7))));
          added++;
        end
      end
    end
  endtask

  // Wait until every result is back, then let the pipeline drain
  task automatic settle();
    while (results_seen != items_issued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_NOMINAL_TICKS:  cfg_nominal   = value[15:0];
      CFG_SAMPLES_PERIOD: cfg_samples   = value[15:0];
      CFG_SAMPLE_NS:      cfg_sample_ns = value;
      CFG_SYNC_NS:        cfg_sync_ns   = value;
      CFG_TICK_NS:        cfg_tick      = value[7:0];
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] nominal, input logic [15:0] samples,
                                input logic [31:0] sample_ns, input logic [31:0] sync_ns,
                                input logic [7:0] tick);
    write_reg(CFG_NOMINAL_TICKS, {16'h0, nominal});
    write_reg(CFG_SAMPLES_PERIOD, {16'h0, samples});
    write_reg(CFG_SAMPLE_NS, sample_ns);
    write_reg(CFG_SYNC_NS, sync_ns);
    write_reg(CFG_TICK_NS, {24'h0, tick});
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer: reset, directed requests, then phases of random traffic,
  // each under its own register setting
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] sample_ns;
    clear_compensator();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Directed part, under the reset register values
    queue_directed(OP_TICK, 1'b0, '0);                 // nothing pending: no compensation
    for (int c = OP_START + 1; c < 8; c++) queue_directed(3'(c), 1'b1, '1);  // spare codes
    queue_directed(OP_START, 1'b0, '1);
    queue_directed(OP_PERIOD, 1'b0, '0);               // timestamp wraps; no reply stored yet
    queue_directed(OP_SAMPLE, 1'b0, '0);
    queue_directed(OP_TICK, 1'b0, '0);                 // spend one step
    queue_directed(OP_REQUEST, 1'b0, 64'hFFFF_FFFF);
    queue_directed(OP_REQUEST, 1'b0, '0);              // request while pending: clear all
    queue_directed(OP_REQUEST, 1'b0, '0);
    queue_directed(OP_SAMPLE, 1'b1, {32'hFFFF_FFFF, 16'hFFFF});
    queue_directed(OP_PERIOD, 1'b0, '0);               // reply far above nominal: slow down
    queue_directed(OP_SAMPLE, 1'b0, '0);               // fraction carry
    queue_directed(OP_SAMPLE, 1'b0, '0);               // pending count saturates
    queue_directed(OP_TICK, 1'b0, '0);
    queue_directed(OP_SAMPLE, 1'b1, {16'h0, RST_NOMINAL_TICKS, 16'h0});  // reply at nominal
    queue_directed(OP_PERIOD, 1'b0, '0);
    queue_directed(OP_SAMPLE, 1'b1, '0);               // reply of zero: speed up
    queue_directed(OP_PERIOD, 1'b0, '0);
    queue_directed(OP_SAMPLE, 1'b0, '0);
    queue_directed(OP_START, 1'b0, '0);
    queue_directed(OP_REQUEST, 1'b0, {32'h0, $urandom});
    queue_directed(OP_TICK, 1'b0, '0);
    queue_sync_traffic(PHASE_ITEMS);
    settle();

    // Lower extremes
    apply_settings(16'd1, 16'd1, 32'd1, 32'd1, 8'd2);
    queue_sync_traffic(PHASE_ITEMS);
    settle();

    // Upper extremes: the speeding increment reaches 256
    apply_settings(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    queue_sync_traffic(PHASE_ITEMS);
    settle();

    // Zero tick: the slowing increment floors at zero; the compare value
    // lands exactly on the sync interval before it wraps
    apply_settings(16'd50, 16'd7, 32'd3, 32'd9, 8'd0);
    queue_sync_traffic(PHASE_ITEMS);
    settle();

    repeat (4) begin
      sample_ns = $urandom_range(1, 50000);
      apply_settings(16'($urandom_range(1, 5000)), 16'($urandom_range(1, 300)), sample_ns,
                     sample_ns * $urandom_range(1, 16) + $urandom_range(0, sample_ns),
                     8'($urandom_range(2, 255)));
      queue_sync_traffic(PHASE_ITEMS);
      settle();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer the next request at the falling edge, hold it until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (tx_gap > 0) begin
        in_valid <= 1'b0;
        tx_gap--;
      end else if (pending_events.size() > 0) begin
        next_event       = pending_events.pop_front();
        in_valid        <= 1'b1;
        operation       <= next_event.op;
        timer_count     <= next_event.timer;
        reply_valid     <= next_event.rvalid;
        reply_ticks     <= next_event.rticks;
        reply_remainder <= next_event.rrem;
        start_timestamp <= next_event.start_ts;
        tx_gap           = draw_gap(tx_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off while the driver
  // keeps offering, so the block fills and stalls its input
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (!long_hold_done && in_valid && results_seen >= HOLD_OFF_AFTER) begin
      long_hold_done = 1'b1;
      rx_hold        = HOLD_OFF_CYCLES - 1;
      out_ready     <= 1'b0;
    end else begin
      rx_gap = draw_gap(rx_burst);
      out_ready <= (rx_gap == 0);
      if (rx_gap > 0) rx_hold = rx_gap - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on each accepted request, check each accepted result
  // against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    timer_event_t ev;
    comp_result_t want;
    req_taken = !rst && in_valid && in_ready;
    if (req_taken) begin
      ev.op       = operation;
      ev.timer    = timer_count;
      ev.rvalid   = reply_valid;
      ev.rticks   = reply_ticks;
      ev.rrem     = reply_remainder;
      ev.start_ts = start_timestamp;
      advance_compensator(ev, want);
      expected_results.push_back(want);
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result arrived with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        compare_field("compensate_now", 64'(want.comp), 64'(compensate_now));
        compare_field("step_ns", 64'(want.step), 64'(step_ns));
        compare_field("sample_compare", 64'(want.cmp), 64'(sample_compare));
        compare_field("send_valid", 64'(want.sendv), 64'(send_valid));
        compare_field("send_timestamp", 64'(want.sendts), 64'(send_timestamp));
        compare_field("sync_error", 64'(want.err), 64'(sync_error));
        compare_field("next_sync_ts", want.sync_ts, next_sync_ts);
        compare_field("pending_steps", 64'(want.pend), 64'(pending_steps));
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule
